// File: hw/rtl/assert_macros.svh
// assertion macros used by block_dct_quantizer
// no dependencies; simulation builds get checks, synthesis builds get nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/dctq_pkg.sv
// constants, types and the cosine table of the dct quantizer
// no dependencies; used by block_dct_quantizer and its testbench
package dctq_pkg;

    // block geometry (block size is a power of two)
    localparam int BlockSize  = 64;
    localparam int SampleBits = 16;
    localparam int LogBlock   = $clog2(BlockSize);
    localparam int FillBits   = LogBlock + 1;
    localparam int IndexBits  = 6;

    // cosine table
    localparam int CosBits    = 16;
    localparam int CosTabBits = 8;
    localparam int PhaseBits  = LogBlock + 2;
    localparam int IdxWide    = PhaseBits + CosTabBits - 2;

    // datapath widths
    localparam int ProdBits   = SampleBits + CosBits;
    localparam int AccBits    = ProdBits + LogBlock;
    localparam int StepBits   = 16;
    localparam int DenShift   = 7 + LogBlock;
    localparam int NumWide    = AccBits + 1;
    localparam int NumBits    = NumWide - DenShift - 1;
    localparam int DivCntBits = $clog2(NumBits);
    localparam int WordBits   = 24;

    // configuration register map
    localparam int AddrBits   = 4;
    localparam logic [1:0] RegKeepCount = 2'd0;
    localparam logic [1:0] RegCoeffBits = 2'd1;
    localparam logic [1:0] RegQStep     = 2'd2;

    localparam logic [6:0]  KeepReset  = 7'd16;
    localparam logic [4:0]  BitsReset  = 5'd12;
    localparam logic [15:0] QStepReset = 16'd2048;

    typedef enum logic [2:0] {
        StIdle,
        StMac,
        StDrain,
        StDiv,
        StEmit
    } state_t;

    localparam logic signed [CosBits-1:0] QuarterCos [0:64] = '{
        16'sd32767, 16'sd32758, 16'sd32729, 16'sd32679, 16'sd32610, 16'sd32522,
        16'sd32413, 16'sd32286, 16'sd32138, 16'sd31972, 16'sd31786, 16'sd31581,
        16'sd31357, 16'sd31114, 16'sd30853, 16'sd30572, 16'sd30274, 16'sd29957,
        16'sd29622, 16'sd29269, 16'sd28899, 16'sd28511, 16'sd28106, 16'sd27684,
        16'sd27246, 16'sd26791, 16'sd26320, 16'sd25833, 16'sd25330, 16'sd24812,
        16'sd24279, 16'sd23732, 16'sd23170, 16'sd22595, 16'sd22006, 16'sd21403,
        16'sd20788, 16'sd20160, 16'sd19520, 16'sd18868, 16'sd18205, 16'sd17531,
        16'sd16846, 16'sd16151, 16'sd15447, 16'sd14733, 16'sd14010, 16'sd13279,
        16'sd12540, 16'sd11793, 16'sd11039, 16'sd10279, 16'sd9512,  16'sd8740,
        16'sd7962,  16'sd7180,  16'sd6393,  16'sd5602,  16'sd4808,  16'sd4011,
        16'sd3212,  16'sd2411,  16'sd1608,  16'sd804,   16'sd0
    };

    // full-wave cosine in q1.15 built from the quarter wave
    function automatic logic signed [CosBits-1:0] cos_lookup(
        input logic [CosTabBits-1:0] i
    );
        logic [CosTabBits-1:0] mirror;
        logic signed [CosBits-1:0] v;
        begin
            if (i <= 8'd64)
            begin
                mirror = i;
                v      = QuarterCos[mirror[6:0]];
            end
            else if (i <= 8'd128)
            begin
                mirror = 8'd128 - i;
                v      = -QuarterCos[mirror[6:0]];
            end
            else if (i <= 8'd192)
            begin
                mirror = i - 8'd128;
                v      = -QuarterCos[mirror[6:0]];
            end
            else
            begin
                mirror = 8'(9'd256 - {1'b0, i});
                v      = QuarterCos[mirror[6:0]];
            end
            return v;
        end
    endfunction

endpackage

// File: hw/rtl/block_dct_quantizer.sv
// block dct-ii quantizer: sample buffer, shared mac, iterative divider
// depends on dctq_pkg, dctq_ram and assert_macros.svh
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  sample    | in        | sample_valid / sample_ready  | sample, end_of_stream
//  coeff     | out       | coeff_valid / coeff_ready    | coeff_word, coeff_index,
//            |           |                              | last_of_block
//  config    | in        | apb psel/penable/pwrite      | paddr, pwdata, prdata
//
// a sample that does not close its block leaves the sequencer idle, ready for the next sample
// a closing sample starts K coefficients, each passing through the mac over every filled
//   position, a drain of the mac pipeline, 25 divider steps and a hand-off step
// a single multiply-accumulate unit and a one-bit-per-cycle divider serve every coefficient in turn
// reset clears the fill count, the sequencer and the output valid flag; the sample ram
//   needs no clearing since positions at or beyond the fill count are never read
// a stalled coeff request holds the sequencer in its hand-off step; a new sample
//   request is taken as soon as the last coefficient sits in the output register
`include "assert_macros.svh"

module block_dct_quantizer
    import dctq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  logic [SampleBits-1:0] sample,
    input  logic                  end_of_stream,
    // coefficient channel
    output logic                  coeff_valid,
    input  logic                  coeff_ready,
    output logic [WordBits-1:0]   coeff_word,
    output logic [IndexBits-1:0]  coeff_index,
    output logic                  last_of_block,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AddrBits-1:0]   paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [6:0]  keep_count_reg;
    logic [4:0]  coeff_bits_reg;
    logic [15:0] q_step_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KeepReset;
            coeff_bits_reg <= BitsReset;
            q_step_reg     <= QStepReset;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                RegKeepCount: keep_count_reg <= pwdata[6:0];
                RegCoeffBits: coeff_bits_reg <= pwdata[4:0];
                RegQStep:     q_step_reg     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            RegKeepCount: prdata = {25'd0, keep_count_reg};
            RegCoeffBits: prdata = {27'd0, coeff_bits_reg};
            RegQStep:     prdata = {16'd0, q_step_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // clamped working values of the registers
    logic [FillBits-1:0] kc_eff;
    logic [4:0]          bits_eff;
    logic [StepBits-1:0] step_eff;
    logic [WordBits:0]   mask_wide;

    always_comb
    begin
        if (keep_count_reg == 7'd0)
            kc_eff = FillBits'(1);
        else if (keep_count_reg > FillBits'(BlockSize))
            kc_eff = FillBits'(BlockSize);
        else
            kc_eff = keep_count_reg;

        if (coeff_bits_reg < 5'd2)
            bits_eff = 5'd2;
        else if (coeff_bits_reg > 5'd24)
            bits_eff = 5'd24;
        else
            bits_eff = coeff_bits_reg;

        step_eff  = (q_step_reg == 16'd0) ? StepBits'(1) : q_step_reg;
        mask_wide = ((WordBits+1)'(1) << bits_eff) - (WordBits+1)'(1);
    end

    // ---------------------------------------------------------------
    // sequencer and datapath registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [FillBits-1:0]          fill_reg, fill_next;
    logic [IndexBits-1:0]         k_reg, k_next;
    logic [LogBlock-1:0]          j_reg, j_next;
    logic [PhaseBits-1:0]         phase_reg, phase_next;
    logic                         v1_reg, v1_next;     // ram data and cosine valid
    logic                         v2_reg, v2_next;     // product valid
    logic signed [CosBits-1:0]    cos_reg, cos_next;
    logic signed [ProdBits-1:0]   prod_reg, prod_next;
    logic signed [AccBits-1:0]    acc_reg, acc_next;
    logic [NumBits-1:0]           num_reg, num_next;   // dividend, then quotient
    logic [StepBits-1:0]          rem_reg, rem_next;
    logic                         neg_reg, neg_next;
    logic [DivCntBits-1:0]        div_cnt_reg, div_cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [WordBits-1:0]          out_word_reg, out_word_next;
    logic [IndexBits-1:0]         out_index_reg, out_index_next;
    logic                         out_last_reg, out_last_next;

    // sample buffer
    logic                  ram_we;
    logic [SampleBits-1:0] ram_rdata;

    dctq_ram #(
        .Width (SampleBits),
        .Depth (BlockSize)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[LogBlock-1:0]),
        .wdata (sample),
        .raddr (j_reg),
        .rdata (ram_rdata)
    );

    // combinational helpers
    logic [IdxWide-1:0]     idx_wide;
    logic [CosTabBits-1:0]  cos_idx;
    logic [AccBits-1:0]     mag;
    logic [NumWide-1:0]     num_wide;
    logic [StepBits:0]      trial;
    logic                   trial_ge;
    logic [NumBits-1:0]     q_signed;
    logic                   is_last;
    logic [IndexBits-1:0]   last_index;

    always_comb
    begin
        // table index round(m*64/N) mod 256
        idx_wide = (IdxWide'(phase_reg) << (CosTabBits - 2)) + IdxWide'(BlockSize / 2);
        cos_idx  = CosTabBits'(idx_wide >> LogBlock);

        // rounded numerator (2|acc| + den) / 2den, with the power-of-two part shifted out
        mag      = acc_reg[AccBits-1] ? AccBits'(-acc_reg) : AccBits'(acc_reg);
        num_wide = {mag, 1'b0} + (NumWide'(step_eff) << DenShift);

        // one restoring divider step
        trial    = {rem_reg, num_reg[NumBits-1]};
        trial_ge = trial >= {1'b0, step_eff};

        q_signed   = neg_reg ? (NumBits'(0) - num_reg) : num_reg;
        is_last    = (FillBits'(k_reg) + FillBits'(1)) == kc_eff;
        last_index = IndexBits'(kc_eff - FillBits'(1));
    end

    // next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        sample_ready   = 1'b0;

        // mac pipeline: ram read and table -> product -> accumulate
        v1_next   = (state_reg == StMac);
        cos_next  = cos_lookup(cos_idx);
        v2_next   = v1_reg;
        prod_next = ProdBits'($signed(ram_rdata)) * ProdBits'(cos_reg);
        if (v2_reg)
        begin
            acc_next = acc_reg + AccBits'(prod_reg);
        end

        if (out_valid_reg && coeff_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            StIdle:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + FillBits'(1);
                    if (end_of_stream || (fill_reg + FillBits'(1)) == FillBits'(BlockSize))
                    begin
                        k_next     = '0;
                        j_next     = '0;
                        phase_next = '0;
                        acc_next   = '0;
                        state_next = StMac;
                    end
                end
            end

            StMac:
            begin
                // phase m steps by 2k mod 4N per sample position
                j_next     = j_reg + LogBlock'(1);
                phase_next = phase_reg + (PhaseBits'(k_reg) << 1);
                if ((FillBits'(j_reg) + FillBits'(1)) == fill_reg)
                begin
                    state_next = StDrain;
                end
            end

            StDrain:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    neg_next     = acc_reg[AccBits-1];
                    num_next     = num_wide[NumWide-1 -: NumBits];
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = StDiv;
                end
            end

            StDiv:
            begin
                rem_next     = trial_ge ? StepBits'(trial - {1'b0, step_eff})
                                        : trial[StepBits-1:0];
                num_next     = {num_reg[NumBits-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DivCntBits'(1);
                if (div_cnt_reg == DivCntBits'(NumBits - 1))
                begin
                    state_next = StEmit;
                end
            end

            StEmit:
            begin
                if (!out_valid_reg || coeff_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = q_signed[WordBits-1:0] & mask_wide[WordBits-1:0];
                    out_index_next = k_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        fill_next  = '0;
                        state_next = StIdle;
                    end
                    else
                    begin
                        k_next     = k_reg + IndexBits'(1);
                        j_next     = '0;
                        phase_next = PhaseBits'(k_reg + IndexBits'(1));
                        acc_next   = '0;
                        state_next = StMac;
                    end
                end
            end

            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            fill_reg      <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        phase_reg     <= phase_next;
        cos_reg       <= cos_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign coeff_valid   = out_valid_reg;
    assign coeff_word    = out_word_reg;
    assign coeff_index   = out_index_reg;
    assign last_of_block = out_last_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a full block always closes, so an idle buffer is never full
    `ASSERT_IMPLY(a_idle_fill, clk, rst_n, state_reg == StIdle, fill_reg < FillBits'(BlockSize))
    // the mac pipeline is empty whenever samples are being taken
    `ASSERT_IMPLY(a_idle_pipe, clk, rst_n, state_reg == StIdle, !v1_reg && !v2_reg)
    // the divider never runs past its last step
    `ASSERT_IMPLY(a_div_cnt, clk, rst_n, state_reg == StDiv, div_cnt_reg < DivCntBits'(NumBits))
    // the flagged coefficient is the last one kept
    `ASSERT_IMPLY(a_last_idx, clk, rst_n, out_valid_reg && out_last_reg, out_index_reg == last_index)

endmodule

// File: hw/rtl/dctq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dctq_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [0:Depth-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/sv/block_dct_quantizer_tb.sv
// self-checking testbench for block_dct_quantizer: directed and random sample streams
// depends on dctq_pkg and the block's rtl; predicts every coefficient from its own model
module block_dct_quantizer_tb;
    import dctq_pkg::*;

    // the watchdog limit covers the slowest legal gap between accepted requests plus the
    // long receiver hold-off
    localparam int IdleLimit   = 5000;
    localparam int DrainCycles = 100;
    localparam int HoldCycles  = 400;
    localparam int RandomItems = 128;

    // q1.15 quarter cosine wave, entry i = round(32768*cos(2*pi*i/256)), cos 1 held at 32767
    localparam int QuarterWave [0:64] = '{
        32767, 32758, 32729, 32679, 32610, 32522, 32413, 32286,
        32138, 31972, 31786, 31581, 31357, 31114, 30853, 30572,
        30274, 29957, 29622, 29269, 28899, 28511, 28106, 27684,
        27246, 26791, 26320, 25833, 25330, 24812, 24279, 23732,
        23170, 22595, 22006, 21403, 20788, 20160, 19520, 18868,
        18205, 17531, 16846, 16151, 15447, 14733, 14010, 13279,
        12540, 11793, 11039, 10279, 9512, 8740, 7962, 7180,
        6393, 5602, 4808, 4011, 3212, 2411, 1608, 804,
        0
    };

    typedef struct packed {
        logic [WordBits-1:0]  word;
        logic [IndexBits-1:0] index;
        logic                 last;
    } coeff_t;

    typedef enum logic [1:0] {
        ReadyAlways,
        ReadyCoin,
        ReadySparse
    } ready_mode_t;

    // dut ports, every input known from time zero
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  sample_valid  = 1'b0;
    logic                  sample_ready;
    logic [SampleBits-1:0] sample        = '0;
    logic                  end_of_stream = 1'b0;
    logic                  coeff_valid;
    logic                  coeff_ready   = 1'b0;
    logic [WordBits-1:0]   coeff_word;
    logic [IndexBits-1:0]  coeff_index;
    logic                  last_of_block;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [AddrBits-1:0]   paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state: sample block, fill level, register copies, cosine wave
    logic signed [SampleBits-1:0] block_samples [0:BlockSize-1];
    int unsigned                  samples_held;
    logic [6:0]                   keep_setting;
    logic [4:0]                   bits_setting;
    logic [15:0]                  step_setting;
    int                           cos_wave [0:255];

    // coefficients still owed by the block, oldest first
    coeff_t      pending_coeffs [$];
    coeff_t      front_coeff;
    int unsigned error_count = 0;

    // sender burst bookkeeping
    int unsigned burst_left = 0;

    // receiver stall pattern and the long hold-off request
    bit          hold_req   = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    ready_mode_t ready_mode = ReadyAlways;
    logic [1:0]  ready_phase = '0;

    int unsigned idle_cycles = 0;

    block_dct_quantizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .coeff_valid   (coeff_valid),
        .coeff_ready   (coeff_ready),
        .coeff_word    (coeff_word),
        .coeff_index   (coeff_index),
        .last_of_block (last_of_block),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 time unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // dct-ii of the held block, divided by the step and wrapped to the kept bits
    function automatic void quantize_block();
        int unsigned       kc;
        int unsigned       nbits;
        int unsigned       m;
        int unsigned       idx;
        longint            acc;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   q;
        longint unsigned   mask;
        logic              neg;
        coeff_t            c;
        kc = keep_setting;
        if (kc < 1)
            kc = 1;
        if (kc > BlockSize)
            kc = BlockSize;
        nbits = bits_setting;
        if (nbits < 2)
            nbits = 2;
        if (nbits > 24)
            nbits = 24;
        // a zero step counts as the smallest step
        den  = longint'(BlockSize) * 128 * ((step_setting == 16'd0) ? 1 : step_setting);
        mask = (64'd1 << nbits) - 1;
        for (int k = 0; k < kc; k++)
        begin
            acc = 0;
            for (int j = 0; j < BlockSize; j++)
            begin
                m   = ((2 * j + 1) * k) % (4 * BlockSize);
                idx = ((m * 64 + BlockSize / 2) / BlockSize) % 256;
                acc += longint'(block_samples[j]) * longint'(cos_wave[idx]);
            end
            // round half away from zero on the magnitude
            neg = acc < 0;
            mag = neg ? longint'(-acc) : longint'(acc);
            q   = (2 * mag + den) / (2 * den);
            if (neg)
                q = -q;
            c.word  = WordBits'(q & mask);
            c.index = IndexBits'(k);
            c.last  = (k + 1 == kc);
            pending_coeffs.push_back(c);
        end
    endfunction

    // store an accepted sample; a full block or an end-of-stream closes it
    function automatic void note_sample(input logic [SampleBits-1:0] s, input logic e);
        block_samples[samples_held] = s;
        samples_held++;
        if (samples_held == BlockSize || e)
        begin
            quantize_block();
            for (int j = 0; j < BlockSize; j++)
                block_samples[j] = '0;
            samples_held = 0;
        end
    endfunction

    // apb write, setup phase then access phase; the predictor takes the register at the same time
    task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrBits'({reg_sel, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_sel)
            RegKeepCount: keep_setting = value[6:0];
            RegCoeffBits: bits_setting = value[4:0];
            RegQStep:     step_setting = value[15:0];
            default:      ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int unsigned keep, input int unsigned bits,
                              input int unsigned step);
        write_reg(RegKeepCount, keep);
        write_reg(RegCoeffBits, bits);
        write_reg(RegQStep, step);
    endtask

    // one sample request; valid stays high between requests of a burst
    task automatic send_sample(input logic [SampleBits-1:0] s, input logic e);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        sample_valid  <= 1'b1;
        sample        <= s;
        end_of_stream <= e;
        do
            @(posedge clk);
        while (!sample_ready);
        note_sample(s, e);
    endtask

    // drop valid, let every owed coefficient arrive, then give the block time to settle
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        burst_left = 0;
        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [SampleBits-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return SampleBits'(int'($urandom_range(0, 1024)) - 512);
            default: return SampleBits'($urandom_range(0, 65535));
        endcase
    endfunction

    // a block of n samples with random content, closed by end-of-stream when asked
    task automatic send_block(input int unsigned n, input logic close_with_eos);
        for (int i = 0; i < n; i++)
            send_sample(random_sample(), close_with_eos && (i == n - 1));
    endtask

    // ---------------------------------------------------------------- tests

    // reset values of the registers: keep 16, 12 bits, step 8.0
    task automatic test_reset_defaults();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        wait_idle();
    endtask

    // out-of-range and extreme register values, each with a short block
    task automatic test_register_extremes();
        // zero keep count, too few bits and zero step all clamp up
        set_config(0, 0, 0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
        // keep count beyond the block size, bits beyond 24, smallest step
        set_config(127, 31, 1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
        // largest legal settings, largest step
        set_config(64, 24, 65535);
        send_sample(16'h8000, 1'b1);
        wait_idle();
        // a single coefficient at one bit below the minimum width, alternating bit patterns
        set_config(1, 1, 256);
        send_sample(16'd12345, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        wait_idle();
        // just above the limits; an all-zero block
        set_config(65, 25, 128);
        send_sample(16'h0000, 1'b1);
        wait_idle();
        // lowest legal settings
        set_config(1, 2, 1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // the receiver holds off for a long stretch while samples keep coming,
    // so the output stalls the sequencer and the sample channel backs up
    task automatic test_output_backpressure();
        set_config(16, 16, 64);
        hold_req = 1'b1;
        for (int b = 0; b < 4; b++)
            send_block(3, 1'b1);
        wait_idle();
    endtask

    // sender stops between blocks until every coefficient is home
    task automatic test_sender_pause();
        send_block(5, 1'b1);
        wait_idle();
        send_block(2, 1'b1);
        wait_idle();
    endtask

    // random settings per phase; mostly short end-of-stream blocks, a few full ones
    task automatic test_random_stream();
        int unsigned items_sent;
        int unsigned full_blocks;
        int unsigned keep;
        int unsigned step;
        int unsigned len;
        items_sent  = 0;
        full_blocks = 0;
        while (items_sent < RandomItems)
        begin
            keep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
            case ($urandom_range(0, 4))
                0:       step = 0;
                1:       step = $urandom_range(1, 255);
                2:       step = $urandom_range(256, 4095);
                default: step = $urandom_range(0, 65535);
            endcase
            // upper bits of the write data are noise the registers must ignore
            write_reg(RegKeepCount, ($urandom & ~32'h7F) | keep);
            write_reg(RegCoeffBits, ($urandom & ~32'h1F) | $urandom_range(0, 31));
            write_reg(RegQStep, ($urandom & ~32'hFFFF) | step);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        // block closed by filling up
                        if (full_blocks < 2)
                        begin
                            send_block(BlockSize, 1'b0);
                            full_blocks++;
                            items_sent += BlockSize;
                        end
                    end
                    1:
                    begin
                        // end-of-stream on the sample that also fills the block
                        if (full_blocks < 2)
                        begin
                            send_block(BlockSize, 1'b1);
                            full_blocks++;
                            items_sent += BlockSize;
                        end
                    end
                    default:
                    begin
                        len = $urandom_range(1, 12);
                        send_block(len, 1'b1);
                        items_sent += len;
                    end
                endcase
            end
            wait_idle();
        end
    endtask

    // ---------------------------------------------------------------- processes

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HoldCycles;
        end
        ready_phase <= ready_phase + 2'd1;
        if (hold_left != 0)
        begin
            hold_left--;
            coeff_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (ready_mode)
                ReadyAlways: coeff_ready <= 1'b1;
                ReadyCoin:   coeff_ready <= 1'($urandom_range(0, 1));
                ReadySparse: coeff_ready <= (ready_phase == 2'd0);
                default:     coeff_ready <= 1'b1;
            endcase
        end
    end

    // each accepted coefficient against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && coeff_valid && coeff_ready)
        begin
            if (pending_coeffs.size() == 0)
            begin
                $error("coefficient with nothing owed: index %0d word %0h",
                       coeff_index, coeff_word);
                error_count++;
            end
            else
            begin
                front_coeff = pending_coeffs.pop_front();
                if (coeff_word !== front_coeff.word)
                begin
                    $error("coeff_word: expected %0h, got %0h", front_coeff.word, coeff_word);
                    error_count++;
                end
                if (coeff_index !== front_coeff.index)
                begin
                    $error("coeff_index: expected %0d, got %0d",
                           front_coeff.index, coeff_index);
                    error_count++;
                end
                if (last_of_block !== front_coeff.last)
                begin
                    $error("last_of_block: expected %0b, got %0b",
                           front_coeff.last, last_of_block);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n && ((sample_valid && sample_ready) || (coeff_valid && coeff_ready)))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        // full-wave cosine from the quarter wave
        for (int i = 0; i < 256; i++)
        begin
            if (i <= 64)
                cos_wave[i] = QuarterWave[i];
            else if (i <= 128)
                cos_wave[i] = -QuarterWave[128 - i];
            else if (i <= 192)
                cos_wave[i] = -QuarterWave[i - 128];
            else
                cos_wave[i] = QuarterWave[256 - i];
        end
        for (int j = 0; j < BlockSize; j++)
            block_samples[j] = '0;
        samples_held = 0;
        // register values after reset
        keep_setting = 7'd16;
        bits_setting = 5'd12;
        step_setting = 16'd2048;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_stream();

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
